// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file cdas_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CDAS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CDAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cdas_pkg.sv =====
// ----------------------------------------------------------------------------
// cdas_pkg
// Types, constants and calendar helpers for the date shifter.
// ----------------------------------------------------------------------------
package cdas_pkg;

  localparam int DAY_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [6:0] R100_LAST = 7'd99;
  localparam logic [8:0] R400_LAST = 9'd399;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        kind;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        valid;
    logic [6:0]  r100;
    logic [8:0]  r400;
    logic [4:0]  mlen;
  } item_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Leap rule from the year's residues mod 4, 100 and 400.
  function automatic logic leap_of(input logic [1:0] y4, input logic [6:0] r100,
                                   input logic [8:0] r400);
    return (r400 == 9'd0) || ((y4 == 2'd0) && (r100 != 7'd0));
  endfunction

endpackage

// ===== rtl/core/calendar_date_add_subtract_days.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add_subtract_days
// Gregorian date shifter: moves a date forward or back by a count of days.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive the request fields and raise push;
//   the request is taken on a clock edge where push is high and full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on the result ports; raise pop to take it.
//   Each request gives exactly one result, in request order.
// Operation:
//   The front registers and classifies a request; the back then walks the
//   date one whole year or one month per cycle, then places the day and
//   loads the result register. Invalid dates and clamped results finish
//   early. The back's stepping loop sets the rate, as the back takes the
//   next request only after it has emitted the last; the front and a
//   two-entry queue keep accepting meanwhile.
// Reset (rst, synchronous, active high) empties the queue and the result
//   register. A stalled receiver holds the result; the back waits with the
//   next result, then the queue and the front fill and full goes high.
// ----------------------------------------------------------------------------
module calendar_date_add_subtract_days import cdas_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic [4:0]                start_day,
  input  logic [3:0]                start_month,
  input  logic [13:0]               start_year,
  input  logic [DAY_COUNT_BITS-1:0] day_count,
  output logic                      empty,
  input  logic                      pop,
  output logic [4:0]                result_day,
  output logic [3:0]                result_month,
  output logic [13:0]               result_year,
  output logic                      input_valid,
  output logic                      out_of_range,
  output logic                      result_leap,
  output logic [4:0]                result_month_length
);

  localparam int QW = $bits(item_t) + DAY_COUNT_BITS;

  // front to queue
  logic                      f_push;
  item_t                     f_item;
  logic [DAY_COUNT_BITS-1:0] f_cnt;

  // queue to back
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  logic [QW-1:0]             q_rd_data;
  item_t                     b_item;
  logic [DAY_COUNT_BITS-1:0] b_cnt;

  assign b_item = item_t'(q_rd_data[QW-1:DAY_COUNT_BITS]);
  assign b_cnt  = q_rd_data[DAY_COUNT_BITS-1:0];

  // Classify the request: residues of the year, month length, date check.
  cdas_front #(
    .DAY_COUNT_BITS(DAY_COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .start_day  (start_day),
    .start_month(start_month),
    .start_year (start_year),
    .day_count  (day_count),
    .q_push     (f_push),
    .q_full     (q_full),
    .q_item     (f_item),
    .q_cnt      (f_cnt)
  );

  // Hold classified requests so the front runs ahead of the stepper.
  cdas_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_push),
    .wr_data({f_item, f_cnt}),
    .q_full (q_full),
    .rd     (q_pop),
    .rd_data(q_rd_data),
    .q_empty(q_empty)
  );

  // Walk the date and present the result.
  cdas_back #(
    .DAY_COUNT_BITS(DAY_COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (q_empty),
    .q_item             (b_item),
    .q_cnt              (b_cnt),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .result_day         (result_day),
    .result_month       (result_month),
    .result_year        (result_year),
    .input_valid        (input_valid),
    .out_of_range       (out_of_range),
    .result_leap        (result_leap),
    .result_month_length(result_month_length)
  );

endmodule

// ===== rtl/core/cdas_front.sv =====
// ----------------------------------------------------------------------------
// cdas_front
// Accepts requests, works out the year residues and checks the start date.
// ----------------------------------------------------------------------------
module cdas_front import cdas_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic [4:0]                start_day,
  input  logic [3:0]                start_month,
  input  logic [13:0]               start_year,
  input  logic [DAY_COUNT_BITS-1:0] day_count,
  output logic                      q_push,
  input  logic                      q_full,
  output item_t                     q_item,
  output logic [DAY_COUNT_BITS-1:0] q_cnt
);

  logic                      f_valid;
  logic                      f_kind;
  logic [4:0]                f_day;
  logic [3:0]                f_month;
  logic [13:0]               f_year;
  logic [DAY_COUNT_BITS-1:0] f_cnt;
  logic [7:0]                f_q100;

  logic [26:0] prod;
  logic        accept;
  logic [14:0] q100x100;
  logic [13:0] rem;
  logic [6:0]  r100;
  logic [8:0]  r400;
  logic        leap;
  logic [4:0]  mlen;

  // year / 100 as a reciprocal multiply, exact for any 14-bit year
  assign prod   = {13'd0, start_year} * 27'd5243;
  assign q_push = f_valid && !q_full;
  assign full   = f_valid && q_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind  <= kind;
      f_day   <= start_day;
      f_month <= start_month;
      f_year  <= start_year;
      f_cnt   <= day_count;
      f_q100  <= prod[26:19];
    end
  end

  always_comb begin
    q100x100 = {7'd0, f_q100} * 15'd100;
    rem      = f_year - q100x100[13:0];
    r100     = rem[6:0];
    r400     = 9'({f_q100[1:0], 2'b00} * 7'd25 + {2'b00, r100});
    leap     = leap_of(f_year[1:0], r100, r400);
    mlen     = month_len(f_month, leap);

    q_item.kind  = f_kind;
    q_item.day   = f_day;
    q_item.month = f_month;
    q_item.year  = f_year;
    q_item.r100  = r100;
    q_item.r400  = r400;
    q_item.mlen  = mlen;
    // a bad month gives length 0, which also fails the day check
    q_item.valid = (f_year >= YEAR_MIN) && (f_year <= YEAR_MAX) &&
                   (f_day != 5'd0) && (f_day <= mlen);
    q_cnt        = f_cnt;
  end

endmodule

// ===== rtl/core/cdas_queue.sv =====
// ----------------------------------------------------------------------------
// cdas_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module cdas_queue import cdas_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign q_full  = (count == CW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/cdas_back.sv =====
// ----------------------------------------------------------------------------
// cdas_back
// Steps the date by whole years, then months, then places the day; clamps at the calendar ends.
// ----------------------------------------------------------------------------
module cdas_back import cdas_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  item_t                     q_item,
  input  logic [DAY_COUNT_BITS-1:0] q_cnt,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [4:0]                result_day,
  output logic [3:0]                result_month,
  output logic [13:0]               result_year,
  output logic                      input_valid,
  output logic                      out_of_range,
  output logic                      result_leap,
  output logic [4:0]                result_month_length
);

  localparam int TW = DAY_COUNT_BITS + 1;

  back_state_t state, state_next;

  logic          kind;
  logic [13:0]   year;
  logic [3:0]    month;
  logic [4:0]    day;
  logic [6:0]    r100;
  logic [8:0]    r400;
  logic [TW-1:0] total;
  logic          valid;
  logic          oor;
  logic          out_valid;

  logic          lp_cur, lp_nx, lp_pv, yr_leap;
  logic [TW-1:0] yr_len, mo_len_w;
  logic [4:0]    mo_len;
  logic          take_year, take_month, at_limit_y, at_limit_m;
  logic          load, emit;
  logic [6:0]    r100_inc, r100_dec;
  logic [8:0]    r400_inc, r400_dec;

  always_comb begin
    lp_cur   = leap_of(year[1:0], r100, r400);
    lp_nx    = (r400 == R400_LAST) || ((year[1:0] == 2'd3) && (r100 != R100_LAST));
    lp_pv    = (r400 == 9'd1) || ((year[1:0] == 2'd1) && (r100 != 7'd1));
    // the span of one year holds the February that lies inside it
    yr_leap  = kind ? ((month >= MONTH_FEB) ? lp_cur : lp_pv)
                    : ((month <= MONTH_FEB) ? lp_cur : lp_nx);
    yr_len   = yr_leap ? TW'(366) : TW'(365);
    mo_len   = month_len(month, lp_cur);
    mo_len_w = TW'(mo_len);

    take_year  = (total >= yr_len);
    take_month = (total >= mo_len_w);
    at_limit_y = kind ? (year == YEAR_MIN) : (year == YEAR_MAX);
    at_limit_m = kind ? ((year == YEAR_MIN) && (month == MONTH_JAN))
                      : ((year == YEAR_MAX) && (month == MONTH_DEC));

    r100_inc = (r100 == R100_LAST) ? 7'd0 : r100 + 7'd1;
    r400_inc = (r400 == R400_LAST) ? 9'd0 : r400 + 9'd1;
    r100_dec = (r100 == 7'd0) ? R100_LAST : r100 - 7'd1;
    r400_dec = (r400 == 9'd0) ? R400_LAST : r400 - 9'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = q_item.valid ? BK_RUN : BK_DONE;
        end
      end
      BK_RUN: begin
        if ((take_year && at_limit_y) || (!take_year && take_month && at_limit_m) ||
            (!take_year && !take_month)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || pop) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load  = 1'b0;
    emit  = 1'b0;
    case (state)
      BK_IDLE: load = !q_empty;
      BK_DONE: emit = !out_valid || pop;
      default: begin
        load = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working date
  always_ff @(posedge clk) begin
    if (load) begin
      kind  <= q_item.kind;
      year  <= q_item.year;
      month <= q_item.month;
      day   <= q_item.day;
      r100  <= q_item.r100;
      r400  <= q_item.r400;
      valid <= q_item.valid;
      oor   <= 1'b0;
      // anchor on the first day (forward) or the last day (backward) of the month
      if (q_item.kind) begin
        total <= TW'(q_item.mlen) - TW'(q_item.day) + TW'(q_cnt);
      end else begin
        total <= TW'(q_item.day) - TW'(1) + TW'(q_cnt);
      end
    end else if (state == BK_RUN) begin
      if ((take_year && at_limit_y) || (!take_year && take_month && at_limit_m)) begin
        // clamp to the end of the calendar
        oor <= 1'b1;
        if (kind) begin
          year  <= YEAR_MIN;
          month <= MONTH_JAN;
          day   <= 5'd1;
          r100  <= 7'd1;
          r400  <= 9'd1;
        end else begin
          year  <= YEAR_MAX;
          month <= MONTH_DEC;
          day   <= 5'd31;
          r100  <= R100_LAST;
          r400  <= R400_LAST;
        end
      end else if (take_year) begin
        total <= total - yr_len;
        if (kind) begin
          year <= year - 14'd1;
          r100 <= r100_dec;
          r400 <= r400_dec;
        end else begin
          year <= year + 14'd1;
          r100 <= r100_inc;
          r400 <= r400_inc;
        end
      end else if (take_month) begin
        total <= total - mo_len_w;
        if (kind) begin
          if (month == MONTH_JAN) begin
            month <= MONTH_DEC;
            year  <= year - 14'd1;
            r100  <= r100_dec;
            r400  <= r400_dec;
          end else begin
            month <= month - 4'd1;
          end
        end else begin
          if (month == MONTH_DEC) begin
            month <= MONTH_JAN;
            year  <= year + 14'd1;
            r100  <= r100_inc;
            r400  <= r400_inc;
          end else begin
            month <= month + 4'd1;
          end
        end
      end else begin
        day <= kind ? 5'(mo_len_w - total) : 5'(total + TW'(1));
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      result_day          <= day;
      result_month        <= month;
      result_year         <= year;
      input_valid         <= valid;
      out_of_range        <= oor;
      result_leap         <= lp_cur;
      result_month_length <= mo_len;
    end
  end

endmodule

// ===== rtl/core/cdas_checker.sv =====
// ----------------------------------------------------------------------------
// cdas_checker
// Port-level checks on the date shifter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdas_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [4:0]  result_day,
  input logic [3:0]  result_month,
  input logic [13:0] result_year,
  input logic        input_valid,
  input logic        out_of_range,
  input logic        result_leap,
  input logic [4:0]  result_month_length
);

  `CDAS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result shown right after reset")
  `CDAS_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result_day) && $stable(result_month) && $stable(result_year) && $stable(result_leap)), "stalled result changed")
  `CDAS_ASSERT(a_date_ok, clk, rst, (!empty && input_valid) |-> (result_month >= 4'd1 && result_month <= 4'd12 && result_day >= 5'd1 && result_day <= result_month_length && result_year >= 14'd1 && result_year <= 14'd9999 && result_month_length >= 5'd28), "shifted date is not a real date")
  `CDAS_ASSERT(a_oor_valid, clk, rst, (!empty && out_of_range) |-> input_valid, "range flag on a passed-through date")

endmodule

bind calendar_date_add_subtract_days cdas_checker u_cdas_checker (
  .clk                (clk),
  .rst                (rst),
  .empty              (empty),
  .pop                (pop),
  .result_day         (result_day),
  .result_month       (result_month),
  .result_year        (result_year),
  .input_valid        (input_valid),
  .out_of_range       (out_of_range),
  .result_leap        (result_leap),
  .result_month_length(result_month_length)
);

// ===== bench/date_shift_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_shift_checker
// Watches the request and result queues of the date shifter, predicts each
// shifted date from the accepted request and compares it with the result.
// ----------------------------------------------------------------------------
module date_shift_checker import cdas_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic                      kind,
  input  logic [4:0]                start_day,
  input  logic [3:0]                start_month,
  input  logic [13:0]               start_year,
  input  logic [DAY_COUNT_BITS-1:0] day_count,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [4:0]                result_day,
  input  logic [3:0]                result_month,
  input  logic [13:0]               result_year,
  input  logic                      input_valid,
  input  logic                      out_of_range,
  input  logic                      result_leap,
  input  logic [4:0]                result_month_length,
  output int                        mismatches,
  output int                        pending,
  output int                        requests_seen,
  output int                        invalid_seen,
  output int                        clamped_seen
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        valid;
    logic        clamped;
    logic        leap;
    logic [4:0]  mlen;
  } shifted_date_t;

  shifted_date_t expected_dates[$];
  int            bad_results;
  int            results_seen;
  int            accepted;
  int            invalid_count;
  int            clamped_count;

  assign mismatches    = bad_results;
  assign pending       = accepted - results_seen;
  assign requests_seen = accepted;
  assign invalid_seen  = invalid_count;
  assign clamped_seen  = clamped_count;

  function automatic logic leap_year(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic logic [4:0] days_in_month(input int m, input int y);
    logic [4:0] n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 5'd31;
      4, 6, 9, 11:           n = 5'd30;
      2:                     n = leap_year(y) ? 5'd29 : 5'd28;
      default:               n = 5'd0;
    endcase
    return n;
  endfunction

  // Days since 1 March of year 0; years start in March so the leap day is last.
  function automatic longint day_serial(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  function automatic void serial_to_date(input longint z, output int y, output int m,
                                         output int d);
    longint era, doe, yoe, yr, doy, mp, dd, mm;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr  = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dd  = doy - (153 * mp + 2) / 5 + 1;
    mm  = (mp < 10) ? mp + 3 : mp - 9;
    if (mm <= 2) yr++;
    y = int'(yr);
    m = int'(mm);
    d = int'(dd);
  endfunction

  function automatic shifted_date_t shift_date(input logic k, input logic [4:0] d,
                                               input logic [3:0] m, input logic [13:0] y,
                                               input logic [DAY_COUNT_BITS-1:0] n);
    shifted_date_t r;
    longint        z, first_day, last_day;
    int            ny, nm, nd;
    r = '{day: d, month: m, year: y, valid: 1'b0, clamped: 1'b0, leap: 1'b0, mlen: 5'd0};
    if (m >= MONTH_JAN && m <= MONTH_DEC && y >= YEAR_MIN && y <= YEAR_MAX &&
        d >= 5'd1 && d <= days_in_month(int'(m), int'(y))) begin
      first_day = day_serial(longint'(YEAR_MIN), longint'(MONTH_JAN), longint'(1));
      last_day  = day_serial(longint'(YEAR_MAX), longint'(MONTH_DEC), longint'(31));
      z = day_serial(longint'(y), longint'(m), longint'(d));
      z = k ? z - longint'(n) : z + longint'(n);
      r.valid = 1'b1;
      if (z < first_day) begin
        z = first_day;
        r.clamped = 1'b1;
      end else if (z > last_day) begin
        z = last_day;
        r.clamped = 1'b1;
      end
      serial_to_date(z, ny, nm, nd);
      r.day   = nd[4:0];
      r.month = nm[3:0];
      r.year  = ny[13:0];
    end
    r.leap = leap_year(int'(r.year));
    r.mlen = days_in_month(int'(r.month), int'(r.year));
    return r;
  endfunction

  always @(posedge clk) begin
    shifted_date_t got, want;
    if (rst) begin
      expected_dates.delete();
    end else begin
      // Check the result first: it can never belong to a request taken on this edge.
      if (pop && !empty) begin
        got = {result_day, result_month, result_year, input_valid, out_of_range,
               result_leap, result_month_length};
        if (expected_dates.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("[%0t] result %0d with no request outstanding: %0d/%0d/%0d",
                     $realtime, results_seen, got.day, got.month, got.year);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10)
              $display({"[%0t] result %0d: expected d/m/y %0d/%0d/%0d valid %0b oor %0b ",
                        "leap %0b len %0d, got %0d/%0d/%0d valid %0b oor %0b leap %0b len %0d"},
                       $realtime, results_seen, want.day, want.month, want.year, want.valid,
                       want.clamped, want.leap, want.mlen, got.day, got.month, got.year,
                       got.valid, got.clamped, got.leap, got.mlen);
          end
        end
        results_seen++;
      end
      if (push && !full) begin
        want = shift_date(kind, start_day, start_month, start_year, day_count);
        expected_dates.push_back(want);
        accepted++;
        if (!want.valid) invalid_count++;
        if (want.clamped) clamped_count++;
      end
    end
  end

endmodule

// ===== bench/tb_calendar_date_add_subtract_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_add_subtract_days
// Stimulus and verdict for the Gregorian date shifter: directed corner dates,
// then random requests with random idling on both queues; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_calendar_date_add_subtract_days import cdas_pkg::*;;

  localparam int DCB          = DAY_COUNT_BITS_DEF;
  localparam int RANDOM_COUNT = 1850;
  // Allow the slowest request a full extra round after drain.
  localparam int DRAIN_CYCLES = 250;
  // Worst-case cost of every request, taken several times over.
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic           clk;
  logic           rst;
  logic           push;
  logic           full;
  logic           kind;
  logic [4:0]     start_day;
  logic [3:0]     start_month;
  logic [13:0]    start_year;
  logic [DCB-1:0] day_count;
  logic           empty;
  logic           pop;
  logic [4:0]     result_day;
  logic [3:0]     result_month;
  logic [13:0]    result_year;
  logic           input_valid;
  logic           out_of_range;
  logic           result_leap;
  logic [4:0]     result_month_length;

  int   mismatches;
  int   pending;
  int   requests_seen;
  int   invalid_seen;
  int   clamped_seen;
  int   cycle_count;
  int   directed_sent;
  // Set for stretches of requests where neither side idles.
  logic no_idle;

  calendar_date_add_subtract_days DUT (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .kind                (kind),
    .start_day           (start_day),
    .start_month         (start_month),
    .start_year          (start_year),
    .day_count           (day_count),
    .empty               (empty),
    .pop                 (pop),
    .result_day          (result_day),
    .result_month        (result_month),
    .result_year         (result_year),
    .input_valid         (input_valid),
    .out_of_range        (out_of_range),
    .result_leap         (result_leap),
    .result_month_length (result_month_length)
  );

  date_shift_checker #(.DAY_COUNT_BITS(DCB)) u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .kind                (kind),
    .start_day           (start_day),
    .start_month         (start_month),
    .start_year          (start_year),
    .day_count           (day_count),
    .empty               (empty),
    .pop                 (pop),
    .result_day          (result_day),
    .result_month        (result_month),
    .result_year         (result_year),
    .input_valid         (input_valid),
    .out_of_range        (out_of_range),
    .result_leap         (result_leap),
    .result_month_length (result_month_length),
    .mismatches          (mismatches),
    .pending             (pending),
    .requests_seen       (requests_seen),
    .invalid_seen        (invalid_seen),
    .clamped_seen        (clamped_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run: count cycles and give up at the limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  // Draw the idle cycles for one handshake; none inside a no-idle stretch.
  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Drive one request. Enter and leave at a falling edge; push stays high
  // across back-to-back requests so it is never lowered and raised in one step.
  task automatic send_request(input logic k, input logic [4:0] d, input logic [3:0] m,
                              input logic [13:0] y, input logic [DCB-1:0] n);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    kind        <= k;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    day_count   <= n;
    // Hold the request until an edge sees push with full low.
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: stall a random number of cycles, then pop until one is taken.
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic           k;
    logic [4:0]     d;
    logic [3:0]     m;
    logic [13:0]    y;
    logic [DCB-1:0] n;
    int             sel;
    int             span;

    // Drive every input to a known value before the first edge.
    rst         = 1'b1;
    push        = 1'b0;
    kind        = 1'b0;
    start_day   = '0;
    start_month = '0;
    start_year  = '0;
    day_count   = '0;
    no_idle     = 1'b0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: zero count, month and year rollovers, leap days,
    // invalid start days, months and years, and clamping at both year limits.
    send_request(1'b0, 5'd15, 4'd6,  14'd2023, 16'd0);
    send_request(1'b0, 5'd28, 4'd2,  14'd2024, 16'd1);
    send_request(1'b0, 5'd28, 4'd2,  14'd2023, 16'd1);
    send_request(1'b0, 5'd31, 4'd12, 14'd1999, 16'd1);
    send_request(1'b1, 5'd1,  4'd1,  14'd2000, 16'd1);
    send_request(1'b1, 5'd1,  4'd3,  14'd1900, 16'd1);
    send_request(1'b0, 5'd29, 4'd2,  14'd2000, 16'd365);
    send_request(1'b0, 5'd29, 4'd2,  14'd1900, 16'd10);
    send_request(1'b1, 5'd29, 4'd2,  14'd2023, 16'd10);
    send_request(1'b0, 5'd0,  4'd5,  14'd2010, 16'd3);
    send_request(1'b0, 5'd31, 4'd4,  14'd2010, 16'd3);
    send_request(1'b0, 5'd10, 4'd0,  14'd2010, 16'd3);
    send_request(1'b1, 5'd10, 4'd13, 14'd2010, 16'd3);
    send_request(1'b1, 5'd31, 4'd15, 14'd9999, 16'hFFFF);
    send_request(1'b0, 5'd1,  4'd1,  14'd0,    16'd5);
    send_request(1'b0, 5'd31, 4'd12, 14'd9999, 16'd1);
    send_request(1'b1, 5'd1,  4'd1,  14'd1,    16'd1);
    send_request(1'b0, 5'd1,  4'd1,  14'd1,    16'hFFFF);
    send_request(1'b1, 5'd31, 4'd12, 14'd9999, 16'hFFFF);
    send_request(1'b0, 5'd31, 4'd12, 14'd9999, 16'd0);
    send_request(1'b1, 5'd1,  4'd1,  14'd1,    16'd0);
    send_request(1'b0, 5'd1,  4'd1,  14'd9900, 16'hFFFF);
    send_request(1'b1, 5'd1,  4'd1,  14'd100,  16'hFFFF);
    send_request(1'b1, 5'd15, 4'd3,  14'd2000, 16'hFFFF);
    directed_sent = 24;

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      // Every 150 requests, decide whether the next stretch runs without idling.
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);

      sel = $urandom_range(0, 99);
      k   = 1'($urandom_range(0, 1));
      if (sel < 10) begin
        // Noise: any day and month the ports allow, years up to 9999, often invalid dates.
        d = 5'($urandom_range(0, 31));
        m = 4'($urandom_range(0, 15));
        y = ($urandom_range(0, 3) == 0) ? 14'd0 : 14'($urandom_range(0, 9999));
      end else begin
        m = 4'($urandom_range(1, 12));
        // Weight month ends; a day past the month's end just becomes noise.
        d = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 28))
                                       : 5'($urandom_range(29, 31));
        if (sel < 25)
          y = $urandom_range(0, 1) ? 14'($urandom_range(1, 180))
                                   : 14'($urandom_range(9820, 9999));
        else
          y = 14'($urandom_range(1, 9999));
      end

      // Keep over half the counts short so the stepping stays quick; the rest span the full range.
      span = $urandom_range(0, 99);
      if (span < 35)
        n = DCB'($urandom_range(0, 64));
      else if (span < 60)
        n = DCB'($urandom_range(0, 1000));
      else if (span < 90)
        n = DCB'($urandom);
      else
        n = {DCB{1'b1}} - DCB'($urandom_range(0, 31));

      send_request(k, d, m, y, n);
    end

    // Drop push, drain the results, then allow the block's latency to pass.
    push    <= 1'b0;
    no_idle = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d directed, %0d random) in %0d cycles",
             requests_seen, directed_sent, RANDOM_COUNT, cycle_count);
    $display("Of these %0d had invalid start dates and %0d were clamped at a year limit",
             invalid_seen, clamped_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cdas_pkg.sv
rtl/core/cdas_front.sv
rtl/core/cdas_queue.sv
rtl/core/cdas_back.sv
rtl/core/calendar_date_add_subtract_days.sv
rtl/core/cdas_checker.sv
bench/date_shift_checker.sv
bench/tb_calendar_date_add_subtract_days.sv
